[src/swm_pkg.sv]
// Shared constants and types for the sliding-window minimum filter.
// No dependencies; every other file refers to it by scoped names.
package swm_pkg;

  // Deepest window that the cell row supports, and the index width it implies.
  localparam int unsigned WindowMax = 64;
  localparam int unsigned TapW      = (WindowMax > 1) ? $clog2(WindowMax) : 1;

  // Width of a count of live samples, zero up to the deepest window.
  localparam int unsigned CntW      = $clog2(WindowMax + 1);

  // Fixed field widths of the request and result items.
  localparam int unsigned SampleW = 32;
  localparam int unsigned LenW    = 7;

  // Window length after reset.
  localparam logic [LenW-1:0] LenReset = LenW'(64);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [LenW-1:0]           len_t;
  typedef logic [TapW-1:0]           tap_t;
  typedef logic [CntW-1:0]           cnt_t;

endpackage

[src/swm_in_if.sv]
// Request channel of the sliding-window minimum filter: one sample per request.
// Depends on swm_pkg for the sample type.
interface swm_in_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t sample;
  logic             end_of_stream;

  modport source (output valid, output sample, output end_of_stream, input ready);
  modport sink (input valid, input sample, input end_of_stream, output ready);
endinterface

[src/swm_out_if.sv]
// Result channel of the sliding-window minimum filter: one minimum per request.
// Depends on swm_pkg for the sample type.
interface swm_out_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t window_min;

  modport source (output valid, output window_min, input ready);
  modport sink (input valid, input window_min, output ready);
endinterface

[src/sliding_window_minimum.sv]
// Top level of the sliding-window minimum filter: handshakes, window register, output stage.
// Depends on swm_pkg, swm_in_if, swm_out_if and swm_chain.
//
//   channel   dir  payload                          handshake
//   in_i      in   sample (s32), end_of_stream (1)  valid/ready
//   out_o     out  window_min (s32)                 valid/ready
//   cfg       in   window_len (u7)                  cfg_we_i, no wait
//
// One request per cycle is sustained while out_o.ready holds.
// The cells update in the cycle of the request, the output register on out_move.
// Reset empties the window; no clearing pass is needed since the first sample overwrites
// every cell. A stalled result holds the output register and, once the cell stage is
// also full, drops in_i.ready until out_o.ready returns.
module sliding_window_minimum (
  input  logic          clk_i,
  input  logic          rst_ni,
  swm_in_if.sink        in_i,
  swm_out_if.source     out_o,
  input  logic          cfg_we_i,
  input  swm_pkg::len_t cfg_wdata_i
);

  swm_pkg::len_t    window_len_q;
  logic             restart_q;
  logic             cell_vld_q;
  logic             out_vld_q;
  swm_pkg::sample_t out_min_q;
  swm_pkg::cnt_t    span;
  swm_pkg::cnt_t    live_q;
  swm_pkg::cnt_t    live_d;
  swm_pkg::tap_t    tap;
  swm_pkg::sample_t tap_min;
  logic             in_fire;
  logic             out_move;

  // Window length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= swm_pkg::LenReset;
    end else if (cfg_we_i) begin
      window_len_q <= cfg_wdata_i;
    end
  end

  // Effective window: a zero length acts as one, lengths beyond the row saturate.
  always_comb begin
    if (window_len_q == '0) begin
      span = swm_pkg::CntW'(1);
    end else if (32'(window_len_q) > swm_pkg::WindowMax) begin
      span = swm_pkg::CntW'(swm_pkg::WindowMax);
    end else begin
      span = swm_pkg::CntW'(window_len_q);
    end
  end

  // Live samples: grows by one per request up to the window, so samples that a
  // shorter window has already expired stay out after the window grows again.
  always_comb begin
    if (restart_q) begin
      live_d = swm_pkg::CntW'(1);
    end else if (live_q >= span) begin
      live_d = span;
    end else begin
      live_d = live_q + swm_pkg::CntW'(1);
    end
  end

  // The staged request reads the cell that spans its live samples.
  assign tap = swm_pkg::TapW'(live_q - swm_pkg::CntW'(1));

  // Flow control: the output register frees up when its result is taken.
  assign out_move    = cell_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !cell_vld_q || out_move;
  assign in_fire     = in_i.valid && in_i.ready;

  // After reset or an end of stream, the next sample restarts the window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q  <= 1'b1;
      live_q     <= '0;
      cell_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        restart_q <= in_i.end_of_stream;
        live_q    <= live_d;
      end
      if (in_fire) begin
        cell_vld_q <= 1'b1;
      end else if (out_move) begin
        cell_vld_q <= 1'b0;
      end
      if (out_move) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  swm_chain u_chain (
    .clk_i      (clk_i),
    .shift_en_i (in_fire),
    .restart_i  (restart_q),
    .sample_i   (in_i.sample),
    .tap_i      (tap),
    .tap_min_o  (tap_min)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_move) begin
      out_min_q <= tap_min;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.window_min = out_min_q;

endmodule

[src/swm_cell.sv]
// One cell of the running-minimum row: holds the minimum of the last k+1 samples.
// Depends on swm_pkg for the sample type.
module swm_cell (
  input  logic             clk_i,
  input  logic             shift_en_i,
  input  logic             restart_i,
  input  swm_pkg::sample_t sample_i,
  input  swm_pkg::sample_t prev_i,
  output swm_pkg::sample_t min_o
);

  swm_pkg::sample_t min_q;
  swm_pkg::sample_t min_d;

  // The neighbor's minimum covers one sample less; fold in the new sample.
  // At the start of a stream the neighbor holds stale data and is ignored.
  always_comb begin
    if (!restart_i && (prev_i < sample_i)) begin
      min_d = prev_i;
    end else begin
      min_d = sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      min_q <= min_d;
    end
  end

  assign min_o = min_q;

endmodule

[src/swm_chain.sv]
// Row of running-minimum cells plus the tap that picks the window's cell.
// Depends on swm_pkg and swm_cell.
module swm_chain (
  input  logic             clk_i,
  input  logic             shift_en_i,
  input  logic             restart_i,
  input  swm_pkg::sample_t sample_i,
  input  swm_pkg::tap_t    tap_i,
  output swm_pkg::sample_t tap_min_o
);

  swm_pkg::sample_t cell_min [swm_pkg::WindowMax];

  // Cell k takes its neighbor's minimum; the first cell sees the sample itself.
  for (genvar k = 0; k < swm_pkg::WindowMax; k++) begin : g_cell
    swm_pkg::sample_t prev;
    if (k == 0) begin : g_first
      assign prev = sample_i;
    end else begin : g_next
      assign prev = cell_min[k-1];
    end

    swm_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (shift_en_i),
      .restart_i  (restart_i),
      .sample_i   (sample_i),
      .prev_i     (prev),
      .min_o      (cell_min[k])
    );
  end

  // Cell (live sample count - 1) holds the minimum over the live samples.
  assign tap_min_o = cell_min[tap_i];

endmodule
